/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rae_pkg.sv */
// Types and constants of the regression affine evaluator.
package rae_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int SLOTS        = MAX_CLUSTERS + 1;

    localparam int POINT_W = 10;
    localparam int SLOT_W  = 5;
    localparam int DATA_W  = 32;
    localparam int CC_W    = 5;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PRED_AW = $clog2(SLOTS);
    localparam int CONST_AW = $clog2(MAX_POINTS);
    localparam int COEF_AW = $clog2(MAX_POINTS * SLOTS);
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + $clog2(SLOTS + 2);
    localparam int FRAC_W  = 16;
    localparam int Q_W     = ACC_W - FRAC_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLEMENTAL  = 4'd1;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

    typedef enum logic [1:0] {
        REQ_WR_COEF  = 2'd0,
        REQ_WR_CONST = 2'd1,
        REQ_WR_PRED  = 2'd2,
        REQ_EVAL     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_CONST,
        ST_WAIT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_req                      req_type;
        logic [POINT_W-1:0]        point_index;
        logic [SLOT_W-1:0]         slot_index;
        logic signed [DATA_W-1:0]  data_value;
    } t_in_item;

    typedef struct packed {
        logic [POINT_W-1:0]        result_point;
        logic signed [DATA_W-1:0]  result_value;
        logic                      overflow_flag;
    } t_out_item;

    // One MAC term moving down the read/multiply/accumulate pipe.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic is_const;
    } t_mac_cmd;

    typedef struct packed {
        logic                      coef_we;
        logic                      const_we;
        logic                      pred_we;
        logic [COEF_AW-1:0]        coef_addr;
        logic [CONST_AW-1:0]       const_addr;
        logic [PRED_AW-1:0]        pred_addr;
        logic signed [DATA_W-1:0]  data;
    } t_tbl_wr;

    typedef struct packed {
        t_mac_cmd                  cmd;
        logic [COEF_AW-1:0]        coef_addr;
        logic [CONST_AW-1:0]       const_addr;
        logic [PRED_AW-1:0]        pred_addr;
    } t_tbl_rd;

    typedef struct packed {
        logic idle;
        logic load;
    } t_seq_stat;

endpackage

/* rtl/rae_tables.sv */
// Coefficient, constant and predictor memories with registered read data.
module rae_tables (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rae_pkg::t_tbl_wr                   i_wr,
    input  rae_pkg::t_tbl_rd                   i_rd,
    output rae_pkg::t_mac_cmd                  o_cmd,
    output logic signed [rae_pkg::DATA_W-1:0]  o_coef,
    output logic signed [rae_pkg::DATA_W-1:0]  o_const,
    output logic signed [rae_pkg::DATA_W-1:0]  o_pred
);

    logic signed [rae_pkg::DATA_W-1:0] r_coef_mem  [rae_pkg::MAX_POINTS*rae_pkg::SLOTS];
    logic signed [rae_pkg::DATA_W-1:0] r_const_mem [rae_pkg::MAX_POINTS];
    logic signed [rae_pkg::DATA_W-1:0] r_pred_mem  [rae_pkg::SLOTS];

    logic signed [rae_pkg::DATA_W-1:0] r_coef;
    logic signed [rae_pkg::DATA_W-1:0] r_const;
    logic signed [rae_pkg::DATA_W-1:0] r_pred;
    rae_pkg::t_mac_cmd                 r_cmd;

    always_ff @(posedge i_clk) begin
        if (i_wr.coef_we) begin
            r_coef_mem[i_wr.coef_addr] <= i_wr.data;
        end
        r_coef <= r_coef_mem[i_rd.coef_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.const_we) begin
            r_const_mem[i_wr.const_addr] <= i_wr.data;
        end
        r_const <= r_const_mem[i_rd.const_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.pred_we) begin
            r_pred_mem[i_wr.pred_addr] <= i_wr.data;
        end
        r_pred <= r_pred_mem[i_rd.pred_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_rd.cmd;
        end
    end

    assign o_cmd   = r_cmd;
    assign o_coef  = r_coef;
    assign o_const = r_const;
    assign o_pred  = r_pred;

endmodule

/* rtl/rae_mac.sv */
// Shared multiply-accumulate unit: registered product, exact wide accumulator.
module rae_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rae_pkg::t_mac_cmd                  i_cmd,
    input  logic signed [rae_pkg::DATA_W-1:0]  i_op_a,
    input  logic signed [rae_pkg::DATA_W-1:0]  i_op_b,
    output logic                               o_done,
    output logic signed [rae_pkg::ACC_W-1:0]   o_acc
);

    logic signed [rae_pkg::PROD_W-1:0] n_prod;
    logic signed [rae_pkg::PROD_W-1:0] r_prod;
    rae_pkg::t_mac_cmd                 r_prod_cmd;
    logic signed [rae_pkg::ACC_W-1:0]  n_acc;
    logic signed [rae_pkg::ACC_W-1:0]  r_acc;
    logic                              r_done;

    assign n_prod = i_op_a * i_op_b;

    always_comb begin
        if (r_prod_cmd.first) begin
            n_acc = rae_pkg::ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + rae_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_prod_cmd.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_cmd <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_cmd <= i_cmd;
            r_done     <= r_prod_cmd.valid && r_prod_cmd.last;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

/* rtl/rae_seq.sv */
// Evaluation sequencer: walks the slots of one point, then the point constant.
`include "assert_macros.svh"

module rae_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rae_pkg::POINT_W-1:0]        i_point,
    input  logic [rae_pkg::CC_W-1:0]           i_cluster_count,
    input  logic                               i_sup_en,
    input  logic                               i_mac_done,
    input  logic                               i_out_free,
    output rae_pkg::t_tbl_rd                   o_rd,
    output rae_pkg::t_seq_stat                 o_stat
);

    rae_pkg::t_state                r_state;
    rae_pkg::t_state                n_state;
    logic [rae_pkg::CNT_W-1:0]      r_slot;
    logic [rae_pkg::CNT_W-1:0]      r_total;
    logic [rae_pkg::COEF_AW-1:0]    r_row_base;
    logic [rae_pkg::CONST_AW-1:0]   r_const_addr;
    logic [rae_pkg::CC_W-1:0]       eff_count;
    logic [rae_pkg::CNT_W-1:0]      start_total;

    always_comb begin
        if (i_cluster_count > rae_pkg::CC_W'(rae_pkg::MAX_CLUSTERS)) begin
            eff_count = rae_pkg::CC_W'(rae_pkg::MAX_CLUSTERS);
        end else begin
            eff_count = i_cluster_count;
        end
        start_total = rae_pkg::CNT_W'(eff_count) + rae_pkg::CNT_W'(i_sup_en);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rae_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (start_total == '0) ? rae_pkg::ST_CONST : rae_pkg::ST_SLOT;
                end
            end
            rae_pkg::ST_SLOT: begin
                if (r_slot == r_total - 1'b1) begin
                    n_state = rae_pkg::ST_CONST;
                end
            end
            rae_pkg::ST_CONST: begin
                n_state = rae_pkg::ST_WAIT;
            end
            rae_pkg::ST_WAIT: begin
                if (i_mac_done) begin
                    n_state = rae_pkg::ST_RESULT;
                end
            end
            rae_pkg::ST_RESULT: begin
                if (i_out_free) begin
                    n_state = rae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rae_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rd            = '0;
        o_rd.coef_addr  = r_row_base + rae_pkg::COEF_AW'(r_slot);
        o_rd.const_addr = r_const_addr;
        o_rd.pred_addr  = rae_pkg::PRED_AW'(r_slot);
        o_stat          = '0;
        case (r_state)
            rae_pkg::ST_IDLE: begin
                o_stat.idle = 1'b1;
            end
            rae_pkg::ST_SLOT: begin
                o_rd.cmd.valid = 1'b1;
                o_rd.cmd.first = (r_slot == '0);
            end
            rae_pkg::ST_CONST: begin
                o_rd.cmd.valid    = 1'b1;
                o_rd.cmd.first    = (r_total == '0);
                o_rd.cmd.last     = 1'b1;
                o_rd.cmd.is_const = 1'b1;
            end
            rae_pkg::ST_WAIT: begin
            end
            rae_pkg::ST_RESULT: begin
                o_stat.load = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rae_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rae_pkg::ST_IDLE && i_start) begin
            r_slot       <= '0;
            r_total      <= start_total;
            r_row_base   <= rae_pkg::COEF_AW'(i_point) * rae_pkg::COEF_AW'(rae_pkg::SLOTS);
            r_const_addr <= rae_pkg::CONST_AW'(i_point);
        end else if (r_state == rae_pkg::ST_SLOT) begin
            r_slot <= r_slot + 1'b1;
        end
    end

    `ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, i_mac_done, r_state == rae_pkg::ST_WAIT)
    `ASSERT_IMPL(a_cmd_in_issue, i_clk, i_rst_n, o_rd.cmd.valid, r_state == rae_pkg::ST_SLOT || r_state == rae_pkg::ST_CONST)
    `ASSERT_NEXT(a_const_then_wait, i_clk, i_rst_n, r_state == rae_pkg::ST_CONST, r_state == rae_pkg::ST_WAIT)

endmodule

/* rtl/regression_affine_evaluator.sv */
// Top level of the regression affine evaluator.
// Write transactions (coefficient, constant, predictor) are taken whenever the input is
// ready. An evaluate transaction holds the input ready low from acceptance until its
// result is loaded into the output register, waiting while an older result is not taken.
// Per term (effective cluster count, plus one when the supplemental term is on) it does
// one coefficient read and one multiply-accumulate through a single 32x32 multiplier,
// then the constant term, then a three-stage read/multiply/accumulate drain and saturation.
// The result sits in an output register; writes are still taken while it waits.
`include "assert_macros.svh"

module regression_affine_evaluator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rae_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rae_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rae_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rae_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [rae_pkg::CC_W-1:0]           r_cluster_count;
    logic                               r_sup_en;
    logic                               r_point_ok;
    logic                               r_out_valid;
    rae_pkg::t_out_item                 r_out;

    logic                               in_accept;
    logic                               start;
    logic                               point_ok;
    logic                               slot_ok;
    logic                               out_free;
    rae_pkg::t_tbl_wr                   tbl_wr;
    rae_pkg::t_tbl_rd                   tbl_rd;
    rae_pkg::t_seq_stat                 seq_stat;
    rae_pkg::t_mac_cmd                  tbl_cmd;
    logic signed [rae_pkg::DATA_W-1:0]  coef_q;
    logic signed [rae_pkg::DATA_W-1:0]  const_q;
    logic signed [rae_pkg::DATA_W-1:0]  pred_q;
    logic signed [rae_pkg::DATA_W-1:0]  op_a;
    logic signed [rae_pkg::DATA_W-1:0]  op_b;
    logic                               mac_done;
    logic signed [rae_pkg::ACC_W-1:0]   acc;
    logic signed [rae_pkg::Q_W-1:0]     q;
    logic                               sat_ovf;
    logic signed [rae_pkg::DATA_W-1:0]  sat_value;

    assign o_in_ready  = seq_stat.idle;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign start       = in_accept && (i_in_data.req_type == rae_pkg::REQ_EVAL);
    assign point_ok    = 32'(i_in_data.point_index) < rae_pkg::MAX_POINTS;
    assign slot_ok     = i_in_data.slot_index < rae_pkg::SLOT_W'(rae_pkg::SLOTS);
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= rae_pkg::CC_W'(1);
            r_sup_en        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rae_pkg::CFG_CLUSTER_COUNT: r_cluster_count <= i_cfg_data[rae_pkg::CC_W-1:0];
                rae_pkg::CFG_SUPPLEMENTAL:  r_sup_en        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        tbl_wr            = '0;
        tbl_wr.coef_addr  = rae_pkg::COEF_AW'(i_in_data.point_index)
                            * rae_pkg::COEF_AW'(rae_pkg::SLOTS)
                            + rae_pkg::COEF_AW'(i_in_data.slot_index);
        tbl_wr.const_addr = rae_pkg::CONST_AW'(i_in_data.point_index);
        tbl_wr.pred_addr  = rae_pkg::PRED_AW'(i_in_data.slot_index);
        tbl_wr.data       = i_in_data.data_value;
        if (in_accept) begin
            case (i_in_data.req_type)
                rae_pkg::REQ_WR_COEF:  tbl_wr.coef_we  = point_ok && slot_ok;
                rae_pkg::REQ_WR_CONST: tbl_wr.const_we = point_ok;
                rae_pkg::REQ_WR_PRED:  tbl_wr.pred_we  = slot_ok;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_point_ok <= point_ok;
        end
    end

    rae_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_point         (i_in_data.point_index),
        .i_cluster_count (r_cluster_count),
        .i_sup_en        (r_sup_en),
        .i_mac_done      (mac_done),
        .i_out_free      (out_free),
        .o_rd            (tbl_rd),
        .o_stat          (seq_stat)
    );

    rae_tables u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tbl_wr),
        .i_rd    (tbl_rd),
        .o_cmd   (tbl_cmd),
        .o_coef  (coef_q),
        .o_const (const_q),
        .o_pred  (pred_q)
    );

    assign op_a = tbl_cmd.is_const ? const_q : pred_q;
    assign op_b = tbl_cmd.is_const ? rae_pkg::ONE_Q16 : coef_q;

    rae_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    // Drop the low fraction bits (floor), then clamp to 32 bits.
    always_comb begin
        q       = acc[rae_pkg::ACC_W-1:rae_pkg::FRAC_W];
        sat_ovf = q[rae_pkg::Q_W-1:rae_pkg::DATA_W-1]
                  != {(rae_pkg::Q_W - rae_pkg::DATA_W + 1){q[rae_pkg::DATA_W-1]}};
        if (!sat_ovf) begin
            sat_value = q[rae_pkg::DATA_W-1:0];
        end else if (q[rae_pkg::Q_W-1]) begin
            sat_value = {1'b1, {(rae_pkg::DATA_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(rae_pkg::DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.load) begin
            r_out.result_point  <= rae_pkg::POINT_W'(tbl_rd.const_addr);
            r_out.result_value  <= r_point_ok ? sat_value : '0;
            r_out.overflow_flag <= r_point_ok && sat_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMPL(a_ovf_is_clamped, i_clk, i_rst_n, o_out_valid && o_out_data.overflow_flag, o_out_data.result_value == 32'sh7FFF_FFFF || o_out_data.result_value == 32'sh8000_0000)

endmodule

/* bench/regression_affine_evaluator_checker.sv */
// Checker for the regression affine evaluator: predicts results and compares them.
`timescale 1ns / 1ps

module regression_affine_evaluator_checker
    import rae_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_in_item                i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_out_item               i_out_data,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam logic signed [71:0] Q16_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q16_MIN = -72'sd2147483648;

    logic signed [DATA_W-1:0] coef_tbl  [0:MAX_POINTS*SLOTS-1];
    logic signed [DATA_W-1:0] const_tbl [0:MAX_POINTS-1];
    logic signed [DATA_W-1:0] pred_vec  [0:SLOTS-1];
    logic [CC_W-1:0]          cluster_sel = 5'd1;
    logic                     supp_on = 1'b0;
    t_out_item                expected_results[$];
    int                       fail_count = 0;

    initial begin
        for (int i = 0; i < MAX_POINTS * SLOTS; i++) coef_tbl[i] = '0;
        for (int i = 0; i < MAX_POINTS; i++) const_tbl[i] = '0;
        for (int i = 0; i < SLOTS; i++) pred_vec[i] = '0;
    end

    function automatic t_out_item regression_value(input logic [POINT_W-1:0] pt);
        t_out_item              res;
        int                     n;
        int                     base;
        logic signed [63:0]     prod;
        logic signed [71:0]     acc;
        logic signed [71:0]     cx;
        logic signed [71:0]     q;
        n = (cluster_sel > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cluster_sel);
        base = int'(pt) * SLOTS;
        acc = '0;
        for (int s = 0; s < n; s++) begin
            prod = pred_vec[s] * coef_tbl[base + s];
            acc = acc + prod;
        end
        if (supp_on) begin
            prod = pred_vec[n] * coef_tbl[base + n];
            acc = acc + prod;
        end
        cx = const_tbl[pt];
        acc = acc + (cx <<< FRAC_W);
        q = acc >>> FRAC_W;
        res.result_point = pt;
        res.overflow_flag = 1'b0;
        if (q > Q16_MAX) begin
            res.result_value = 32'sh7FFF_FFFF;
            res.overflow_flag = 1'b1;
        end else if (q < Q16_MIN) begin
            res.result_value = 32'sh8000_0000;
            res.overflow_flag = 1'b1;
        end else begin
            res.result_value = q[DATA_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        int        idx;
        if (!i_rst_n) begin
            cluster_sel = 5'd1;
            supp_on = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CLUSTER_COUNT) cluster_sel = i_cfg_data[CC_W-1:0];
                else if (i_cfg_index == CFG_SUPPLEMENTAL) supp_on = i_cfg_data[0];
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, point", got.result_point, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.result_point !== want.result_point)
                        report_mismatch("result_point", got.result_point, want.result_point);
                    if (got.result_value !== want.result_value)
                        report_mismatch("result_value", got.result_value, want.result_value);
                    if (got.overflow_flag !== want.overflow_flag)
                        report_mismatch("overflow_flag", got.overflow_flag, want.overflow_flag);
                end
            end
            if (i_in_valid && i_in_ready) begin
                idx = int'(i_in_data.point_index) * SLOTS + int'(i_in_data.slot_index);
                case (i_in_data.req_type)
                    REQ_WR_COEF: begin
                        if (i_in_data.slot_index < SLOTS) coef_tbl[idx] = i_in_data.data_value;
                    end
                    REQ_WR_CONST: begin
                        const_tbl[i_in_data.point_index] = i_in_data.data_value;
                    end
                    REQ_WR_PRED: begin
                        if (i_in_data.slot_index < SLOTS)
                            pred_vec[i_in_data.slot_index] = i_in_data.data_value;
                    end
                    REQ_EVAL: begin
                        expected_results.push_back(regression_value(i_in_data.point_index));
                    end
                    default: begin
                        report_mismatch("request type", i_in_data.req_type, 0);
                    end
                endcase
            end
        end
        o_pending <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

/* bench/regression_affine_evaluator_tb.sv */
// Testbench top for the regression affine evaluator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module regression_affine_evaluator_tb;
    import rae_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    t_in_item               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;

    logic                   quiet = 1'b0;
    int                     ready_run = 0;
    int                     cycle_count = 0;
    int                     phase_count = 0;
    int                     cc_eff = 1;
    logic                   supp_en = 1'b0;
    bit                     coef_wr  [0:MAX_POINTS*SLOTS-1];
    bit                     const_wr [0:MAX_POINTS-1];
    bit                     pred_wr  [0:SLOTS-1];

    regression_affine_evaluator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    regression_affine_evaluator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result-side backpressure in bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (ready_run == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                ready_run <= $urandom_range(0, 5);
            end else begin
                out_ready <= 1'b1;
                ready_run <= $urandom_range(1, 12);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 0;
                    3: v = -1;
                    default: v = ONE_Q16;
                endcase
            end
            1, 2, 3: v = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_point();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 1) ? $urandom_range(0, 7) : 1016 + $urandom_range(0, 7);
        return $urandom_range(0, MAX_POINTS - 1);
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic issue(input t_req req, input int pt, input int slot,
                         input logic signed [DATA_W-1:0] value);
        t_in_item item;
        item.req_type = req;
        item.point_index = pt[POINT_W-1:0];
        item.slot_index = slot[SLOT_W-1:0];
        item.data_value = value;
        case (req)
            REQ_WR_COEF: if (slot < SLOTS) coef_wr[pt * SLOTS + slot] = 1'b1;
            REQ_WR_CONST: const_wr[pt] = 1'b1;
            REQ_WR_PRED: if (slot < SLOTS) pred_wr[slot] = 1'b1;
            default: ;
        endcase
        if (!(slot >= SLOTS && (req == REQ_WR_COEF || req == REQ_WR_PRED)))
            phase_count++;
        send_item(item);
    endtask

    // fill whatever the evaluation will read, then evaluate
    task automatic eval_point(input int pt);
        int terms;
        terms = cc_eff + (supp_en ? 1 : 0);
        for (int s = 0; s < terms; s++) begin
            if (!coef_wr[pt * SLOTS + s]) issue(REQ_WR_COEF, pt, s, rand_value());
            if (!pred_wr[s]) issue(REQ_WR_PRED, $urandom_range(0, 1023), s, rand_value());
        end
        if (!const_wr[pt]) issue(REQ_WR_CONST, pt, $urandom_range(0, 31), rand_value());
        issue(REQ_EVAL, pt, $urandom_range(0, 31), rand_value());
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CLUSTER_COUNT)
            cc_eff = (val[CC_W-1:0] > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(val[CC_W-1:0]);
        else if (idx == CFG_SUPPLEMENTAL)
            supp_en = val[0];
    endtask

    task automatic configure(input int ph);
        logic [CFG_DATA_W-1:0] cc_val;
        logic [CFG_DATA_W-1:0] supp_val;
        case (ph)
            1: begin cc_val = 8'd16; supp_val = 8'h01; end
            2: begin cc_val = 8'h00; supp_val = 8'hFF; end
            3: begin cc_val = 8'hFF; supp_val = 8'hFE; end
            4: begin cc_val = 8'h00; supp_val = 8'h00; end
            5: begin cc_val = 8'hE3; supp_val = 8'h01; end
            6: begin
                cc_val = CFG_DATA_W'($urandom_range(0, 255));
                supp_val = CFG_DATA_W'($urandom_range(0, 255));
            end
            default: begin
                cc_val = CFG_DATA_W'($urandom_range(1, MAX_CLUSTERS));
                supp_val = CFG_DATA_W'($urandom_range(0, 1));
            end
        endcase
        write_reg(CFG_CLUSTER_COUNT, cc_val);
        write_reg(CFG_SUPPLEMENTAL, supp_val);
        if (ph == 3) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic directed_items();
        issue(REQ_WR_PRED, 0, 0, 32'sh7FFF_FFFF);
        issue(REQ_WR_COEF, 0, 0, 32'sh7FFF_FFFF);
        issue(REQ_WR_CONST, 0, 0, 32'sh7FFF_FFFF);
        issue(REQ_EVAL, 0, 0, 0);
        issue(REQ_WR_PRED, 0, 31, 0);
        issue(REQ_EVAL, 0, 31, -1);
        issue(REQ_WR_COEF, 1023, 0, 32'sh8000_0000);
        issue(REQ_WR_CONST, 1023, 0, 32'sh8000_0000);
        issue(REQ_EVAL, 1023, 0, 0);
        // tiny negative product truncates down to one LSB below zero
        issue(REQ_WR_PRED, 0, 0, -1);
        issue(REQ_WR_COEF, 1, 0, 1);
        issue(REQ_WR_CONST, 1, 0, 0);
        issue(REQ_EVAL, 1, 0, 0);
        issue(REQ_WR_COEF, 1, 17, rand_value());
        issue(REQ_WR_COEF, 1, 16, 5);
        issue(REQ_WR_PRED, 1023, 0, 32'sh8000_0000);
        issue(REQ_WR_COEF, 2, 0, 32'sh8000_0000);
        issue(REQ_WR_CONST, 2, 0, 32'sh7FFF_FFFF);
        issue(REQ_EVAL, 2, 0, 0);
        issue(REQ_WR_CONST, 1, 0, ONE_Q16);
        issue(REQ_EVAL, 1, 0, 0);
    endtask

    task automatic random_items();
        int r;
        int pt;
        phase_count = 0;
        while (phase_count < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                pt = pick_point();
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 2))
                        0: issue(REQ_WR_COEF, pt, $urandom_range(0, SLOTS - 1), rand_value());
                        1: issue(REQ_WR_CONST, pt, $urandom_range(0, 31), rand_value());
                        default: issue(REQ_WR_PRED, $urandom_range(0, 1023),
                                       $urandom_range(0, SLOTS - 1), rand_value());
                    endcase
                end
                eval_point(pt);
            end else if (r < 75) begin
                eval_point(pick_point());
                eval_point(pick_point());
            end else if (r < 89) begin
                issue(t_req'($urandom_range(0, 2)), $urandom_range(0, 1023),
                      $urandom_range(0, 31), rand_value());
            end else if (r < 99) begin
                issue($urandom_range(0, 1) ? REQ_WR_COEF : REQ_WR_PRED, $urandom_range(0, 1023),
                      $urandom_range(SLOTS, 31), rand_value());
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_POINTS * SLOTS; i++) coef_wr[i] = 1'b0;
        for (int i = 0; i < MAX_POINTS; i++) const_wr[i] = 1'b0;
        for (int i = 0; i < SLOTS; i++) pred_wr[i] = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        random_items();
        for (int ph = 1; ph < PHASES; ph++) begin
            drain();
            configure(ph);
            if (ph == PHASES - 1) quiet = 1'b1;
            random_items();
        end
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
